>>> rtl/core/t2t_pkg.sv
// shared constants, types and command codes of the type 2 tag responder
package t2t_pkg;

  // page memory geometry
  localparam int MEM_PAGES = 64;
  localparam int PAGE_AW   = $clog2(MEM_PAGES);
  // word index counts pages and also the eight signature words
  localparam int IDX_W     = (PAGE_AW > 3) ? PAGE_AW : 3;
  localparam int PAGE_W    = 32;

  // byte limit and bound check widths
  localparam int MB_W      = 9;
  localparam int CAP_BYTES = MEM_PAGES * 4;
  localparam int BOUND_W   = 11;
  localparam logic [MB_W-1:0] CAP           = MB_W'(CAP_BYTES);
  localparam logic [MB_W-1:0] MEM_BYTES_RST = MB_W'(256);

  // configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 64;
  localparam logic [1:0] REG_MEMORY_BYTES      = 2'd0;
  localparam logic [1:0] REG_VERSION_RESPONSE  = 2'd1;
  localparam logic [1:0] REG_VERSION_AVAILABLE = 2'd2;
  localparam logic [1:0] REG_SIGNATURE_ENABLED = 2'd3;

  // command codes
  localparam logic [7:0] CMD_HLTA        = 8'h50;
  localparam logic [7:0] CMD_READ        = 8'h30;
  localparam logic [7:0] CMD_FAST_READ   = 8'h3A;
  localparam logic [7:0] CMD_WRITE       = 8'hA2;
  localparam logic [7:0] CMD_GET_VERSION = 8'h60;
  localparam logic [7:0] CMD_READ_SIG    = 8'h3C;

  // reply tag state
  localparam logic [1:0] TAG_IDLE   = 2'd0;
  localparam logic [1:0] TAG_ACTIVE = 2'd1;
  localparam logic [1:0] TAG_HALT   = 2'd2;

  // configuration seen by the responder
  typedef struct packed {
    logic [MB_W-1:0] memory_bytes;
    logic [63:0]     version_response;
    logic            version_available;
    logic            signature_enabled;
  } cfg_t;

endpackage

>>> rtl/core/t2t_ram.sv
// generic single-port-write, registered-read ram
module t2t_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/t2t_cfg.sv
// apb-style configuration registers of the type 2 tag responder
module t2t_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [t2t_pkg::CFG_AW-1:0]   paddr,
  input  logic [t2t_pkg::CFG_DW-1:0]   pwdata,
  output logic [t2t_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready,
  output t2t_pkg::cfg_t                cfg
);

  logic [t2t_pkg::MB_W-1:0] memory_bytes_r;
  logic [63:0]              version_response_r;
  logic                     version_available_r;
  logic                     signature_enabled_r;
  logic [1:0]               reg_idx;
  logic                     wr_en;

  assign reg_idx = paddr[4:3];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      memory_bytes_r      <= t2t_pkg::MEM_BYTES_RST;
      version_response_r  <= '0;
      version_available_r <= 1'b0;
      signature_enabled_r <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        t2t_pkg::REG_MEMORY_BYTES:      memory_bytes_r      <= pwdata[t2t_pkg::MB_W-1:0];
        t2t_pkg::REG_VERSION_RESPONSE:  version_response_r  <= pwdata;
        t2t_pkg::REG_VERSION_AVAILABLE: version_available_r <= pwdata[0];
        t2t_pkg::REG_SIGNATURE_ENABLED: signature_enabled_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      t2t_pkg::REG_MEMORY_BYTES:
        prdata = t2t_pkg::CFG_DW'(memory_bytes_r);
      t2t_pkg::REG_VERSION_RESPONSE:
        prdata = version_response_r;
      t2t_pkg::REG_VERSION_AVAILABLE:
        prdata = t2t_pkg::CFG_DW'(version_available_r);
      t2t_pkg::REG_SIGNATURE_ENABLED:
        prdata = t2t_pkg::CFG_DW'(signature_enabled_r);
      default:
        prdata = '0;
    endcase
  end

  assign cfg.memory_bytes      = memory_bytes_r;
  assign cfg.version_response  = version_response_r;
  assign cfg.version_available = version_available_r;
  assign cfg.signature_enabled = signature_enabled_r;

endmodule

>>> rtl/core/type2_tag_command_responder.sv
// type 2 tag command responder: frame decode, page memory and reply sequencer
//
// One request is taken at a time; in_stall stays high until the request has been
// decoded and its last reply word has been placed in the output register. A host
// page load gives no reply; an idle, halt or ACK reply is a single result. Page,
// version and signature replies send N words (up to 64 pages) via the single page
// memory read port, each word taking a read and then a send state, stepped by the
// shared index counter; a stalled output holds the sequencer. The next request
// may be accepted while the final reply word still waits in the output register.
// The page memory reads as all zeros after reset through per-page valid flags, so
// no clearing pass is needed. Configuration (memory size, version bytes, feature
// enables) is written at 8-byte spaced addresses; the user must write it only
// while the block is idle, as the block itself does not enforce this.
module type2_tag_command_responder (
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_kind,
  input  logic [2:0]                 in_frame_len,
  input  logic [7:0]                 in_byte_cmd,
  input  logic [7:0]                 in_byte_arg1,
  input  logic [7:0]                 in_byte_arg2,
  input  logic [7:0]                 in_byte_arg3,
  input  logic [7:0]                 in_byte_arg4,
  input  logic [7:0]                 in_byte_arg5,
  // reply channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [31:0]                out_data_word,
  output logic                       out_word_valid,
  output logic                       out_is_ack,
  output logic                       out_last,
  output logic [1:0]                 out_next_state,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [t2t_pkg::CFG_AW-1:0] paddr,
  input  logic [t2t_pkg::CFG_DW-1:0] pwdata,
  output logic [t2t_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_SEND  = 2'd3;

  localparam logic [2:0] ACT_IDLE  = 3'd0;
  localparam logic [2:0] ACT_HALT  = 3'd1;
  localparam logic [2:0] ACT_ACK   = 3'd2;
  localparam logic [2:0] ACT_LOAD  = 3'd3;
  localparam logic [2:0] ACT_PAGES = 3'd4;
  localparam logic [2:0] ACT_VER   = 3'd5;
  localparam logic [2:0] ACT_SIG   = 3'd6;

  localparam logic [1:0] SRC_PAGE = 2'd0;
  localparam logic [1:0] SRC_VER  = 2'd1;
  localparam logic [1:0] SRC_ZERO = 2'd2;

  localparam int PAW = t2t_pkg::PAGE_AW;
  localparam int IW  = t2t_pkg::IDX_W;
  localparam int BW  = t2t_pkg::BOUND_W;

  t2t_pkg::cfg_t cfg;

  logic [1:0]                   state_r, state_nxt;
  logic                         kind_r;
  logic [2:0]                   len_r;
  logic [7:0]                   cmd_r, a1_r, a2_r;
  logic [31:0]                  data_r;
  logic [1:0]                   src_r, src_nxt;
  logic [IW-1:0]                idx_r, idx_nxt, end_r, end_nxt;
  logic                         rd_vld_r;
  logic [t2t_pkg::MEM_PAGES-1:0] vld_r;

  logic                         out_valid_r;
  logic [31:0]                  out_word_r;
  logic                         out_wv_r, out_ack_r, out_last_r;
  logic [1:0]                   out_ns_r;

  logic                         out_load;
  logic [31:0]                  ld_word;
  logic                         ld_wv, ld_ack, ld_last;
  logic [1:0]                   ld_ns;

  logic [2:0]                   act;
  logic [IW-1:0]                first_idx, last_idx;
  logic [1:0]                   act_src;
  logic [t2t_pkg::MB_W-1:0]     lim;
  logic [BW-1:0]                bound_sum;
  logic                         fits, host_ok, out_free;

  logic                         ram_we, ram_re;
  logic [PAW-1:0]               ram_raddr;
  logic [31:0]                  ram_rdata;
  logic [31:0]                  page_word;

  // configuration registers
  t2t_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // page memory
  t2t_ram #(
    .WIDTH (t2t_pkg::PAGE_W),
    .DEPTH (t2t_pkg::MEM_PAGES)
  ) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (a1_r[PAW-1:0]),
    .wdata (data_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign ram_raddr = idx_r[PAW-1:0];
  assign ram_re    = (state_r == ST_READ);
  assign page_word = rd_vld_r ? ram_rdata : 32'd0;

  // shared bound compare against the effective byte limit
  always_comb begin
    lim = (cfg.memory_bytes < t2t_pkg::CAP) ? cfg.memory_bytes : t2t_pkg::CAP;
    case (cmd_r)
      t2t_pkg::CMD_READ:      bound_sum = {1'b0, a1_r, 2'b00} + BW'(16);
      t2t_pkg::CMD_FAST_READ: bound_sum = {1'b0, a2_r, 2'b00} + BW'(4);
      default:                bound_sum = {1'b0, a1_r, 2'b00} + BW'(4);
    endcase
    fits    = (bound_sum <= BW'(lim));
    host_ok = ({1'b0, a1_r} < 9'(t2t_pkg::MEM_PAGES));
  end

  // frame decode
  always_comb begin
    act       = ACT_IDLE;
    act_src   = SRC_PAGE;
    first_idx = a1_r[IW-1:0];
    last_idx  = a1_r[IW-1:0] + IW'(3);
    if (kind_r) begin
      act = ACT_LOAD;
    end else if (len_r != 3'd0) begin
      case (cmd_r)
        t2t_pkg::CMD_HLTA: begin
          if (len_r == 3'd2 && a1_r == 8'd0) act = ACT_HALT;
        end
        t2t_pkg::CMD_READ: begin
          if (len_r == 3'd2 && fits) act = ACT_PAGES;
        end
        t2t_pkg::CMD_FAST_READ: begin
          last_idx = a2_r[IW-1:0];
          if (len_r == 3'd3 && a1_r <= a2_r && fits) act = ACT_PAGES;
        end
        t2t_pkg::CMD_GET_VERSION: begin
          act_src   = SRC_VER;
          first_idx = '0;
          last_idx  = IW'(1);
          if (len_r == 3'd1 && cfg.version_available) act = ACT_VER;
        end
        t2t_pkg::CMD_WRITE: begin
          if (len_r == 3'd6 && fits) act = ACT_ACK;
        end
        t2t_pkg::CMD_READ_SIG: begin
          act_src   = SRC_ZERO;
          first_idx = '0;
          last_idx  = IW'(7);
          if (cfg.signature_enabled && len_r == 3'd2 && a1_r == 8'd0) act = ACT_SIG;
        end
        default: act = ACT_IDLE;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    src_nxt   = src_r;
    idx_nxt   = idx_r;
    end_nxt   = end_r;
    ram_we    = 1'b0;
    out_load  = 1'b0;
    ld_word   = 32'd0;
    ld_wv     = 1'b0;
    ld_ack    = 1'b0;
    ld_last   = 1'b1;
    ld_ns     = t2t_pkg::TAG_IDLE;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        case (act)
          ACT_LOAD: begin
            ram_we    = host_ok;
            state_nxt = ST_IDLE;
          end
          ACT_PAGES, ACT_VER, ACT_SIG: begin
            src_nxt   = act_src;
            idx_nxt   = first_idx;
            end_nxt   = last_idx;
            state_nxt = ST_READ;
          end
          default: begin
            // single-result replies: idle, halt or ACK
            if (out_free) begin
              out_load  = 1'b1;
              ram_we    = (act == ACT_ACK);
              ld_ack    = (act == ACT_ACK);
              ld_ns     = (act == ACT_ACK)  ? t2t_pkg::TAG_ACTIVE :
                          (act == ACT_HALT) ? t2t_pkg::TAG_HALT : t2t_pkg::TAG_IDLE;
              state_nxt = ST_IDLE;
            end
          end
        endcase
      end
      ST_READ: begin
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_wv    = 1'b1;
          ld_ns    = t2t_pkg::TAG_ACTIVE;
          ld_last  = (idx_r == end_r);
          case (src_r)
            SRC_PAGE: ld_word = page_word;
            SRC_VER:  ld_word = (idx_r == '0) ? cfg.version_response[63:32]
                                              : cfg.version_response[31:0];
            default:  ld_word = 32'd0;
          endcase
          if (idx_r == end_r) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = ST_READ;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (ram_we) begin
        vld_r[a1_r[PAW-1:0]] <= 1'b1;
      end
    end
  end

  // request capture, index counter and reply payload
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      kind_r <= in_kind;
      len_r  <= in_frame_len;
      cmd_r  <= in_byte_cmd;
      a1_r   <= in_byte_arg1;
      a2_r   <= in_byte_arg2;
      data_r <= {in_byte_arg2, in_byte_arg3, in_byte_arg4, in_byte_arg5};
    end
    src_r <= src_nxt;
    idx_r <= idx_nxt;
    end_r <= end_nxt;
    if (ram_re) begin
      rd_vld_r <= vld_r[ram_raddr];
    end
    if (out_load) begin
      out_word_r <= ld_word;
      out_wv_r   <= ld_wv;
      out_ack_r  <= ld_ack;
      out_last_r <= ld_last;
      out_ns_r   <= ld_ns;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_word  = out_word_r;
  assign out_word_valid = out_wv_r;
  assign out_is_ack     = out_ack_r;
  assign out_last       = out_last_r;
  assign out_next_state = out_ns_r;

endmodule

>>> tb/sv/tb_type2_tag_command_responder.sv
// self-checking testbench for the type 2 tag command responder
module tb_type2_tag_command_responder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CMD_WRITE_BLOCK = 8'hA0;
  localparam logic [7:0] KNOWN_CMDS [7] = '{t2t_pkg::CMD_HLTA, t2t_pkg::CMD_READ,
                                            t2t_pkg::CMD_FAST_READ, t2t_pkg::CMD_WRITE,
                                            t2t_pkg::CMD_GET_VERSION, t2t_pkg::CMD_READ_SIG,
                                            CMD_WRITE_BLOCK};
  localparam int CYCLE_LIMIT    = 400000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RF_PER_SEGMENT = 27;
  localparam int SEGMENTS       = 6;
  localparam int MAX_REPORTS    = 10;

  // one request as the block sees it
  typedef struct packed {
    logic       kind;
    logic [2:0] frame_len;
    logic [7:0] cmd;
    logic [7:0] arg1;
    logic [7:0] arg2;
    logic [7:0] arg3;
    logic [7:0] arg4;
    logic [7:0] arg5;
  } frame_t;

  // one reply word with its flags
  typedef struct packed {
    logic [31:0] data_word;
    logic        word_valid;
    logic        is_ack;
    logic        last;
    logic [1:0]  next_state;
  } reply_t;

  // tracks tag memory and registers, predicts the replies of each request
  class tag_reply_tracker;
    logic [31:0]              page_copy [t2t_pkg::MEM_PAGES];
    logic [t2t_pkg::MB_W-1:0] mem_bytes;
    logic [63:0]              version_bytes;
    logic                     version_on;
    logic                     sig_on;
    reply_t                   pending_replies [$];
    int                       mismatches;
    int                       checked;

    function new();
      foreach (page_copy[i]) page_copy[i] = '0;
      mem_bytes     = t2t_pkg::MEM_BYTES_RST;
      version_bytes = '0;
      version_on    = 1'b0;
      sig_on        = 1'b0;
      mismatches    = 0;
      checked       = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [63:0] value);
      case (idx)
        t2t_pkg::REG_MEMORY_BYTES:      mem_bytes = value[t2t_pkg::MB_W-1:0];
        t2t_pkg::REG_VERSION_RESPONSE:  version_bytes = value;
        t2t_pkg::REG_VERSION_AVAILABLE: version_on = value[0];
        t2t_pkg::REG_SIGNATURE_ENABLED: sig_on = value[0];
        default: ;
      endcase
    endfunction

    function void add_reply(logic [31:0] word, logic valid, logic ack, logic fin,
                            logic [1:0] st);
      reply_t r;
      r.data_word  = word;
      r.word_valid = valid;
      r.is_ack     = ack;
      r.last       = fin;
      r.next_state = st;
      pending_replies.push_back(r);
    endfunction

    function void add_pages(int unsigned first, int unsigned count);
      int unsigned pg;
      for (int unsigned i = 0; i < count; i++) begin
        pg = first + i;
        add_reply(page_copy[pg[t2t_pkg::PAGE_AW-1:0]], 1'b1, 1'b0, i + 1 == count,
                  t2t_pkg::TAG_ACTIVE);
      end
    endfunction

    // accepted request: update memory and queue the replies it causes
    function void take_frame(frame_t f);
      logic [31:0] data;
      int unsigned lim;
      int unsigned p;
      int unsigned q;
      data = {f.arg2, f.arg3, f.arg4, f.arg5};
      lim  = (mem_bytes < t2t_pkg::CAP_BYTES) ? 32'(mem_bytes) : t2t_pkg::CAP_BYTES;
      p    = 32'(f.arg1);
      q    = 32'(f.arg2);
      // host page load, silent
      if (f.kind) begin
        if (p < t2t_pkg::MEM_PAGES) page_copy[p[t2t_pkg::PAGE_AW-1:0]] = data;
        return;
      end
      if (f.frame_len == 3'd0) begin
        add_reply('0, 1'b0, 1'b0, 1'b1, t2t_pkg::TAG_IDLE);
        return;
      end
      case (f.cmd)
        t2t_pkg::CMD_HLTA: if (f.frame_len == 3'd2 && p == 0) begin
          add_reply('0, 1'b0, 1'b0, 1'b1, t2t_pkg::TAG_HALT);
          return;
        end
        t2t_pkg::CMD_READ: if (f.frame_len == 3'd2 && 4 * p + 16 <= lim) begin
          add_pages(p, 4);
          return;
        end
        t2t_pkg::CMD_FAST_READ: if (f.frame_len == 3'd3 && p <= q && 4 * q + 4 <= lim) begin
          add_pages(p, q - p + 1);
          return;
        end
        t2t_pkg::CMD_GET_VERSION: if (f.frame_len == 3'd1 && version_on) begin
          add_reply(version_bytes[63:32], 1'b1, 1'b0, 1'b0, t2t_pkg::TAG_ACTIVE);
          add_reply(version_bytes[31:0], 1'b1, 1'b0, 1'b1, t2t_pkg::TAG_ACTIVE);
          return;
        end
        t2t_pkg::CMD_WRITE: if (f.frame_len == 3'd6 && 4 * p + 4 <= lim) begin
          if (p < t2t_pkg::MEM_PAGES) page_copy[p[t2t_pkg::PAGE_AW-1:0]] = data;
          add_reply('0, 1'b0, 1'b1, 1'b1, t2t_pkg::TAG_ACTIVE);
          return;
        end
        t2t_pkg::CMD_READ_SIG: if (sig_on && f.frame_len == 3'd2 && p == 0) begin
          for (int k = 0; k < 8; k++)
            add_reply('0, 1'b1, 1'b0, k == 7, t2t_pkg::TAG_ACTIVE);
          return;
        end
        default: ;
      endcase
      // everything else answers idle
      add_reply('0, 1'b0, 1'b0, 1'b1, t2t_pkg::TAG_IDLE);
    endfunction

    function void report(string what, reply_t want, reply_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%t %s: exp %h/%b/%b/%b/%0d got %h/%b/%b/%b/%0d", $realtime, what,
                 want.data_word, want.word_valid, want.is_ack, want.last, want.next_state,
                 got.data_word, got.word_valid, got.is_ack, got.last, got.next_state);
    endfunction

    // accepted reply against the oldest prediction
    function void match_reply(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        report("unexpected reply", '0, got);
        return;
      end
      want = pending_replies.pop_front();
      checked++;
      if (got.data_word !== want.data_word || got.word_valid !== want.word_valid ||
          got.is_ack !== want.is_ack || got.last !== want.last ||
          got.next_state !== want.next_state)
        report("reply mismatch", want, got);
    endfunction
  endclass

  logic                       clk            = 1'b0;
  logic                       rst_n          = 1'b0;
  logic                       in_valid       = 1'b0;
  logic                       in_stall;
  logic                       in_kind        = 1'b0;
  logic [2:0]                 in_frame_len   = '0;
  logic [7:0]                 in_byte_cmd    = '0;
  logic [7:0]                 in_byte_arg1   = '0;
  logic [7:0]                 in_byte_arg2   = '0;
  logic [7:0]                 in_byte_arg3   = '0;
  logic [7:0]                 in_byte_arg4   = '0;
  logic [7:0]                 in_byte_arg5   = '0;
  logic                       out_valid;
  logic                       out_stall      = 1'b0;
  logic [31:0]                out_data_word;
  logic                       out_word_valid;
  logic                       out_is_ack;
  logic                       out_last;
  logic [1:0]                 out_next_state;
  logic                       psel           = 1'b0;
  logic                       penable        = 1'b0;
  logic                       pwrite         = 1'b0;
  logic [t2t_pkg::CFG_AW-1:0] paddr          = '0;
  logic [t2t_pkg::CFG_DW-1:0] pwdata         = '0;
  logic [t2t_pkg::CFG_DW-1:0] prdata;
  logic                       pready;

  tag_reply_tracker tracker = new();
  int send_idle_pct = 28;
  int recv_idle_pct = 53;
  int cycles        = 0;
  int rf_frames     = 0;
  int host_loads    = 0;
  int settings_used = 0;

  type2_tag_command_responder DUT (.*);

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // reply side: check accepted words, stall at random
  always @(posedge clk) begin : reply_side
    reply_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_data_word, out_word_valid, out_is_ack, out_last, out_next_state};
      tracker.match_reply(got);
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  function automatic frame_t make_frame(logic k, logic [2:0] len, logic [7:0] cmd,
                                        logic [7:0] a1, logic [7:0] a2, logic [7:0] a3,
                                        logic [7:0] a4, logic [7:0] a5);
    return {k, len, cmd, a1, a2, a3, a4, a5};
  endfunction

  // mostly well-formed requests with random content, some broken ones and noise
  function automatic frame_t random_frame();
    frame_t f;
    int unsigned pick;
    pick        = $urandom_range(0, 99);
    f.kind      = 1'b0;
    f.frame_len = 3'($urandom);
    f.cmd       = 8'($urandom);
    f.arg1      = 8'($urandom);
    f.arg2      = 8'($urandom);
    f.arg3      = 8'($urandom);
    f.arg4      = 8'($urandom);
    f.arg5      = 8'($urandom);
    if (pick < 12) begin
      f.kind = 1'b1;
      if ($urandom_range(0, 9) != 0) f.arg1 = 8'($urandom_range(0, t2t_pkg::MEM_PAGES - 1));
    end else if (pick < 30) begin
      f.frame_len = 3'd2;
      f.cmd       = t2t_pkg::CMD_READ;
      if ($urandom_range(0, 7) != 0) f.arg1 = 8'($urandom_range(0, t2t_pkg::MEM_PAGES - 1));
    end else if (pick < 44) begin
      f.frame_len = 3'd3;
      f.cmd       = t2t_pkg::CMD_FAST_READ;
      case ($urandom_range(0, 9))
        0: ;
        1: begin
          f.arg1 = 8'd0;
          f.arg2 = 8'(t2t_pkg::MEM_PAGES - 1);
        end
        default: begin
          f.arg1 = 8'($urandom_range(0, t2t_pkg::MEM_PAGES - 1));
          f.arg2 = f.arg1 + 8'($urandom_range(0, 5));
        end
      endcase
    end else if (pick < 58) begin
      f.frame_len = 3'd6;
      f.cmd       = t2t_pkg::CMD_WRITE;
      if ($urandom_range(0, 7) != 0) f.arg1 = 8'($urandom_range(0, t2t_pkg::MEM_PAGES - 1));
    end else if (pick < 65) begin
      f.frame_len = 3'd1;
      f.cmd       = t2t_pkg::CMD_GET_VERSION;
    end else if (pick < 71) begin
      f.frame_len = 3'd2;
      f.cmd       = t2t_pkg::CMD_READ_SIG;
      f.arg1      = 8'd0;
    end else if (pick < 76) begin
      f.frame_len = 3'd2;
      f.cmd       = t2t_pkg::CMD_HLTA;
      f.arg1      = 8'd0;
    end else if (pick < 90) begin
      // known command with a likely wrong length or page
      f.cmd  = KNOWN_CMDS[3'($urandom_range(0, 6))];
      f.arg1 = 8'($urandom_range(0, 3));
    end
    return f;
  endfunction

  // present one request, hold it until accepted
  task automatic send_frame(frame_t f);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= f.kind;
    in_frame_len <= f.frame_len;
    in_byte_cmd  <= f.cmd;
    in_byte_arg1 <= f.arg1;
    in_byte_arg2 <= f.arg2;
    in_byte_arg3 <= f.arg3;
    in_byte_arg4 <= f.arg4;
    in_byte_arg5 <= f.arg5;
    do @(posedge clk); while (in_stall);
    tracker.take_frame(f);
    if (f.kind) host_loads++;
    else rf_frames++;
  endtask

  // stop requests, wait for every predicted reply, let silent work finish
  task automatic drain_replies();
    in_valid <= 1'b0;
    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup and access cycle, write lands when penable and pready are high
  task automatic write_register(logic [1:0] idx, logic [63:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_register(idx, value);
    @(posedge clk);
  endtask

  task automatic apply_setting(logic [8:0] bytes, logic [63:0] version, logic ver_on,
                               logic sig_on);
    drain_replies();
    write_register(t2t_pkg::REG_MEMORY_BYTES, 64'(bytes));
    write_register(t2t_pkg::REG_VERSION_RESPONSE, version);
    write_register(t2t_pkg::REG_VERSION_AVAILABLE, 64'(ver_on));
    write_register(t2t_pkg::REG_SIGNATURE_ENABLED, 64'(sig_on));
    settings_used++;
  endtask

  // extremes and special cases, first with reset registers
  task automatic run_directed();
    send_frame(make_frame(0, 1, t2t_pkg::CMD_GET_VERSION, 0, 0, 0, 0, 0));
    send_frame(make_frame(0, 2, t2t_pkg::CMD_READ_SIG, 0, 0, 0, 0, 0));
    send_frame(make_frame(0, 2, t2t_pkg::CMD_READ, 0, 0, 0, 0, 0));
    send_frame(make_frame(1, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_frame(make_frame(1, 0, 0, 63, 8'h01, 8'h23, 8'h45, 8'h67));
    // host loads past the memory are dropped
    send_frame(make_frame(1, 0, 0, 64, 8'hDE, 8'hAD, 8'hBE, 8'hEF));
    send_frame(make_frame(1, 7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_frame(make_frame(0, 6, t2t_pkg::CMD_WRITE, 1, 8'hA5, 8'h5A, 8'hC3, 8'h3C));
    send_frame(make_frame(0, 6, t2t_pkg::CMD_WRITE, 64, 8'h11, 8'h22, 8'h33, 8'h44));
    send_frame(make_frame(0, 2, t2t_pkg::CMD_READ, 60, 0, 0, 0, 0));
    send_frame(make_frame(0, 2, t2t_pkg::CMD_READ, 61, 0, 0, 0, 0));
    send_frame(make_frame(0, 3, t2t_pkg::CMD_FAST_READ, 0, 63, 0, 0, 0));
    send_frame(make_frame(0, 3, t2t_pkg::CMD_FAST_READ, 5, 4, 0, 0, 0));
    send_frame(make_frame(0, 3, t2t_pkg::CMD_FAST_READ, 63, 64, 0, 0, 0));
    send_frame(make_frame(0, 3, t2t_pkg::CMD_FAST_READ, 8'hFF, 8'hFF, 0, 0, 0));
    send_frame(make_frame(0, 2, t2t_pkg::CMD_HLTA, 0, 0, 0, 0, 0));
    send_frame(make_frame(0, 2, t2t_pkg::CMD_HLTA, 1, 0, 0, 0, 0));
    send_frame(make_frame(0, 0, t2t_pkg::CMD_READ, 0, 0, 0, 0, 0));
    send_frame(make_frame(0, 6, CMD_WRITE_BLOCK, 2, 1, 2, 3, 4));
    send_frame(make_frame(0, 7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    // version and signature switched on
    apply_setting(9'd256, 64'h0123_4567_89AB_CDEF, 1'b1, 1'b1);
    send_frame(make_frame(0, 1, t2t_pkg::CMD_GET_VERSION, 0, 0, 0, 0, 0));
    send_frame(make_frame(0, 2, t2t_pkg::CMD_GET_VERSION, 0, 0, 0, 0, 0));
    send_frame(make_frame(0, 2, t2t_pkg::CMD_READ_SIG, 0, 0, 0, 0, 0));
    send_frame(make_frame(0, 2, t2t_pkg::CMD_READ_SIG, 1, 0, 0, 0, 0));
    send_frame(make_frame(0, 2, t2t_pkg::CMD_READ, 0, 0, 0, 0, 0));
  endtask

  // reset, directed part, random segments, then wait out the replies
  initial begin : stimulus
    frame_t f;
    int     seg_frames;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int s = 0; s < SEGMENTS; s++) begin
      send_idle_pct = (s < 2) ? 28 : (s < 4) ? 53 : 0;
      recv_idle_pct = (s < 2) ? 53 : (s < 4) ? 28 : 0;
      case (s)
        0: apply_setting(9'd256, {$urandom, $urandom}, 1'b1, 1'b1);
        1: apply_setting(9'h1FF, '1, 1'b1, 1'b0);
        2: apply_setting(9'd0, {$urandom, $urandom}, 1'b0, 1'b1);
        3: apply_setting(9'($urandom_range(0, 256)), {$urandom, $urandom}, 1'b1, 1'b1);
        4: apply_setting(9'd255, {$urandom, $urandom}, 1'b0, 1'b0);
        default: apply_setting(9'd256, '0, 1'b1, 1'b1);
      endcase
      seg_frames = 0;
      while (seg_frames < RF_PER_SEGMENT) begin
        f = random_frame();
        send_frame(f);
        if (!f.kind) seg_frames++;
      end
    end
    drain_replies();
    $display("sent %0d tag frames and %0d host page loads over %0d register settings",
             rf_frames, host_loads, settings_used);
    $display("checked %0d reply words, %0d mismatches", tracker.checked, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
